// File: sv/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// shared types and constants for the distance-vector route table
// ----------------------------------------------------------------------------
package dvrt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [15:0] GARBAGE_DELAY_RESET = 16'd120;

	localparam logic [2:0] OP_LEARN   = 3'd0;
	localparam logic [2:0] OP_UNLEARN = 3'd1;
	localparam logic [2:0] OP_TICK    = 3'd2;
	localparam logic [2:0] OP_STATIC  = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;

	localparam logic [2:0] ST_NONE      = 3'd0;
	localparam logic [2:0] ST_REFRESHED = 3'd1;
	localparam logic [2:0] ST_REPLACED  = 3'd2;
	localparam logic [2:0] ST_ADDED     = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_STATIC    = 3'd5;
	localparam logic [2:0] ST_TICK      = 3'd6;
	localparam logic [2:0] ST_CLEARED   = 3'd7;

	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [4:0]  metric;
		logic        stat;
		logic        unreach;
		logic [31:0] expiry;
		logic [31:0] garbage;
	} entry_t;

endpackage

// File: sv/distance_vector_route_table.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table
// route table with learn, unlearn, tick, static add and dynamic clear
// ----------------------------------------------------------------------------
// an operation runs from start through the scan to the strobe; the
//   writeback runs in the strobe cycle and busy stays high until it ends
// a new operation is taken only after busy falls; the scan reads the
//   entry memory through its single read port (one entry per cycle)
// reset: valid bits clear, garbage_delay goes to 120; entry memory not cleared
// results cannot be stalled: the strobe marks a one-cycle transaction
module distance_vector_route_table import dvrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [31:0] dest_addr,
	input  logic [31:0] dest_mask,
	input  logic [31:0] next_hop,
	input  logic [4:0]  route_metric,
	input  logic        marked_unreachable,
	input  logic [31:0] expiry_time,
	input  logic [31:0] now_seconds,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [5:0]  slot,
	output logic [6:0]  made_unreachable,
	output logic [6:0]  freed_count
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;
	localparam logic [1:0] S_WB   = 2'd3;

	// entry memory, one read and one write port
	entry_t mem [TABLE_DEPTH];
	entry_t rd_s1;
	logic [TABLE_DEPTH-1:0] valid_q;

	logic [1:0]  state_q;
	logic [15:0] gdelay_q;
	logic [IDX_W:0] rd_idx_q;   // read address counter
	logic [IDX_W:0] cmp_idx_q;  // index of the entry in rd_s1
	logic        cmp_vld_s1;

	// latched command
	logic [2:0]  op_q;
	logic [31:0] dst_q, msk_q, gw_q, exp_q, now_q;
	logic [4:0]  met_q;
	logic        unr_q;

	logic        match_fnd_q, free_fnd_q;
	logic [IDX_W-1:0] match_idx_q, free_idx_q;
	entry_t      match_ent_q;
	logic [CNT_W-1:0] made_q, freed_q;

	// write port
	logic        we;
	logic [IDX_W-1:0] wa;
	entry_t      wd;
	logic        wb_we_q;
	logic [IDX_W-1:0] wb_idx_q;
	entry_t      wb_ent_q;

	logic [IDX_W-1:0] cur;
	logic        cur_valid;
	logic        is_match, tick_exp, tick_free, clear_hit;
	entry_t      tick_ent;

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign cur = cmp_idx_q[IDX_W-1:0];
	assign cur_valid = cmp_vld_s1 && valid_q[cur];
	assign is_match = cur_valid && ((rd_s1.dest & rd_s1.mask) == (dst_q & msk_q));
	assign tick_exp = cur_valid && !rd_s1.stat && (rd_s1.expiry != 32'd0)
		&& (rd_s1.expiry <= now_q);
	assign tick_free = cur_valid && !rd_s1.stat && !tick_exp
		&& (rd_s1.garbage != 32'd0) && (rd_s1.garbage <= now_q);
	assign clear_hit = cur_valid && !rd_s1.stat;

	always_comb begin
		tick_ent = rd_s1;
		tick_ent.unreach = 1'b1;
		tick_ent.expiry = 32'd0;
		tick_ent.garbage = now_q + {16'd0, gdelay_q};
	end

	// tick rewrites during the scan; learn and friends write back at the end
	always_comb begin
		we = 1'b0;
		wa = cur;
		wd = tick_ent;
		if (state_q == S_SCAN && op_q == OP_TICK && tick_exp) begin
			we = 1'b1;
		end else if (wb_we_q && state_q == S_WB) begin
			we = 1'b1;
			wa = wb_idx_q;
			wd = wb_ent_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_s1 <= mem[rd_idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q <= op;
			dst_q <= dest_addr;
			msk_q <= dest_mask;
			gw_q <= next_hop;
			met_q <= route_metric;
			unr_q <= marked_unreachable;
			exp_q <= expiry_time;
			now_q <= now_seconds;
		end
	end

	// result decision at the end of the scan
	logic [2:0] res_st;
	logic [IDX_W-1:0] res_slot;
	logic res_we;
	entry_t res_ent, new_ent;
	always_comb begin
		new_ent.dest = dst_q;
		new_ent.mask = msk_q;
		new_ent.gateway = gw_q;
		new_ent.metric = met_q;
		new_ent.stat = 1'b0;
		new_ent.unreach = unr_q;
		new_ent.expiry = exp_q;
		new_ent.garbage = 32'd0;
		res_st = ST_NONE;
		res_slot = '0;
		res_we = 1'b0;
		res_ent = new_ent;
		case (op_q)
			OP_LEARN: begin
				if (!match_fnd_q) begin
					if (free_fnd_q) begin
						res_st = ST_ADDED;
						res_slot = free_idx_q;
						res_we = 1'b1;
					end else begin
						res_st = ST_FULL;
					end
				end else begin
					res_slot = match_idx_q;
					if (match_ent_q.stat) begin
						res_st = ST_STATIC;
					end else if ((match_ent_q.unreach && !unr_q)
						|| (match_ent_q.metric > met_q)) begin
						res_st = ST_REPLACED;
						res_we = 1'b1;
					end else if (match_ent_q.gateway == gw_q) begin
						res_st = ST_REFRESHED;
						res_we = 1'b1;
						res_ent = match_ent_q;
						res_ent.expiry = exp_q;
					end
				end
			end
			OP_UNLEARN: begin
				if (match_fnd_q) begin
					res_slot = match_idx_q;
					if (match_ent_q.stat) begin
						res_st = ST_STATIC;
					end else if (match_ent_q.gateway == gw_q) begin
						res_we = 1'b1;
						if (match_ent_q.unreach) begin
							res_st = ST_REFRESHED;
							res_ent = match_ent_q;
							res_ent.expiry = exp_q;
						end else begin
							res_st = ST_REPLACED;
						end
					end
				end
			end
			OP_TICK: res_st = ST_TICK;
			OP_STATIC: begin
				if (free_fnd_q) begin
					res_st = ST_ADDED;
					res_slot = free_idx_q;
					res_we = 1'b1;
					res_ent.stat = 1'b1;
					res_ent.unreach = 1'b0;
					res_ent.expiry = 32'd0;
				end else begin
					res_st = ST_FULL;
				end
			end
			OP_CLEAR: res_st = ST_CLEARED;
			default: res_st = ST_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gdelay_q <= GARBAGE_DELAY_RESET;
			valid_q <= '0;
			rd_idx_q <= '0;
			cmp_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			match_fnd_q <= 1'b0;
			free_fnd_q <= 1'b0;
			match_idx_q <= '0;
			free_idx_q <= '0;
			made_q <= '0;
			freed_q <= '0;
			wb_we_q <= 1'b0;
			wb_idx_q <= '0;
			strobe <= 1'b0;
			status <= ST_NONE;
			slot <= '0;
			made_unreachable <= '0;
			freed_count <= '0;
		end else begin
			strobe <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				gdelay_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						rd_idx_q <= '0;
						cmp_vld_s1 <= 1'b0;
						match_fnd_q <= 1'b0;
						free_fnd_q <= 1'b0;
						made_q <= '0;
						freed_q <= '0;
					end
				end
				S_SCAN: begin
					// issue one read per cycle, compare the entry read last cycle
					cmp_idx_q <= rd_idx_q;
					cmp_vld_s1 <= (rd_idx_q < (IDX_W+1)'(TABLE_DEPTH));
					if (rd_idx_q < (IDX_W+1)'(TABLE_DEPTH)) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (cmp_vld_s1) begin
						if (is_match && !match_fnd_q) begin
							match_fnd_q <= 1'b1;
							match_idx_q <= cur;
							match_ent_q <= rd_s1;
						end
						if (!valid_q[cur] && !free_fnd_q) begin
							free_fnd_q <= 1'b1;
							free_idx_q <= cur;
						end
						if (op_q == OP_TICK) begin
							if (tick_exp) begin
								made_q <= made_q + 1'b1;
							end else if (tick_free) begin
								freed_q <= freed_q + 1'b1;
								valid_q[cur] <= 1'b0;
							end
						end else if (op_q == OP_CLEAR && clear_hit) begin
							freed_q <= freed_q + 1'b1;
							valid_q[cur] <= 1'b0;
						end
						if (cur == IDX_W'(TABLE_DEPTH - 1)) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					strobe <= 1'b1;
					status <= res_st;
					slot <= 6'(res_slot);
					made_unreachable <= 7'(made_q);
					freed_count <= 7'(freed_q);
					wb_we_q <= res_we;
					wb_idx_q <= res_slot;
					wb_ent_q <= res_ent;
					state_q <= S_WB;
				end
				S_WB: begin
					if (wb_we_q) begin
						valid_q[wb_idx_q] <= 1'b1;
					end
					wb_we_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result transaction only leaves the end of a scan
	a_strobe_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q) == S_DONE)
		else $error("strobe without finished scan");
	// every result comes with the writeback state
	a_wb_after_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> state_q == S_WB)
		else $error("no writeback after result");
	// tick and clear never report a slot
	a_bulk_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == ST_TICK || status == ST_CLEARED) |-> slot == 6'd0)
		else $error("bulk operation reported a slot");
	// a full table reports nothing written
	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status == ST_FULL |-> !wb_we_q)
		else $error("write on full table");

endmodule
